### sv/acep_pkg.sv
// Shared types and constants of the ANSI CSI escape parser.
package acep_pkg;

   localparam int MAX_ARGS_DEF  = 16;
   localparam int ARG_WIDTH_DEF = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int EMIT_W        = 4;
   localparam int SLOT_OUT_W    = 4;
   localparam int VALUE_OUT_W   = 16;

   localparam logic [7:0] ESC_BYTE     = 8'h1B;
   localparam logic [7:0] BRACKET_BYTE = 8'h5B;
   localparam logic [7:0] SEMI_BYTE    = 8'h3B;
   localparam logic [7:0] AT_BYTE      = 8'h40;
   localparam logic [7:0] FINAL_LO     = 8'h40;
   localparam logic [7:0] FINAL_HI     = 8'h7E;
   localparam logic [7:0] DIGIT_0      = 8'h30;
   localparam logic [7:0] DIGIT_9      = 8'h39;
   localparam logic [7:0] TAB_BYTE     = 8'h09;
   localparam logic [7:0] CR_BYTE      = 8'h0D;
   localparam logic [7:0] LF_BYTE      = 8'h0A;
   localparam logic [7:0] BS_BYTE      = 8'h08;
   localparam logic [7:0] BEL_BYTE     = 8'h07;

   typedef enum logic [3:0] {
      KIND_CONSUMED     = 4'd0,
      KIND_CHAR         = 4'd1,
      KIND_TAB          = 4'd2,
      KIND_CR           = 4'd3,
      KIND_NEWLINE      = 4'd4,
      KIND_CSI_ARG      = 4'd5,
      KIND_UNKNOWN_ESC  = 4'd6,
      KIND_ABORTED      = 4'd7,
      KIND_INSERT_BLANK = 4'd8
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic [7:0]               code;
      logic [SLOT_OUT_W-1:0]    slot;
      logic [VALUE_OUT_W-1:0]   value;
      logic                     last;
   } result_type;

endpackage

### sv/acep_parser.sv
// Input register, parser state, argument store and argument-run sequencer.
module acep_parser #(
   parameter int MAX_ARGS  = acep_pkg::MAX_ARGS_DEF,
   parameter int ARG_WIDTH = acep_pkg::ARG_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_byte_in,
   input  logic                out_space,
   output logic                out_valid,
   output acep_pkg::result_type out_data
);

   localparam int SLOT_W = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
   localparam int CMP_W  = (SLOT_W > acep_pkg::EMIT_W) ? SLOT_W : acep_pkg::EMIT_W;
   localparam int MUL_W  = ARG_WIDTH + 4;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_ARGS - 1);
   localparam logic [acep_pkg::EMIT_W-1:0] LAST_EMIT =
      acep_pkg::EMIT_W'(acep_pkg::MAX_RESULTS - 1);

   logic                        in_valid_ff, in_valid_in;
   logic [7:0]                  in_byte_ff;
   logic                        in_escape_ff, in_escape_in;
   logic                        bracket_ff, bracket_in;
   logic [SLOT_W-1:0]           slot_ff, slot_in;
   logic [ARG_WIDTH-1:0]        cur_ff, cur_in;
   logic [MAX_ARGS-1:0]         arg_valid_ff, arg_valid_in;
   logic [ARG_WIDTH-1:0]        arg_ff [MAX_ARGS];
   logic [acep_pkg::EMIT_W-1:0] emit_idx_ff, emit_idx_in;

   logic                        fire, consume, wr_en;
   logic [7:0]                  b;
   logic                        is_digit, is_final;
   logic [MUL_W-1:0]            scaled;
   logic [ARG_WIDTH-1:0]        digit_acc;
   logic [CMP_W-1:0]            emit_ext, slot_ext;
   logic [SLOT_W-1:0]           rd_idx;
   logic                        emit_is_cur, emit_last;
   logic [ARG_WIDTH-1:0]        emit_value, arg0;
   acep_pkg::result_type        res;

   assign b        = in_byte_ff;
   assign fire     = in_valid_ff && out_space;
   assign consume  = fire && res.last;
   assign req_ready = !in_valid_ff || consume;
   assign out_valid = fire;
   assign out_data  = res;

   assign is_digit = (b >= acep_pkg::DIGIT_0) && (b <= acep_pkg::DIGIT_9);
   assign is_final = (b >= acep_pkg::FINAL_LO) && (b <= acep_pkg::FINAL_HI);

   assign scaled = MUL_W'({cur_ff, 3'b000}) + MUL_W'({cur_ff, 1'b0})
                 + MUL_W'(b - acep_pkg::DIGIT_0);
   assign digit_acc = (scaled > MUL_W'({ARG_WIDTH{1'b1}})) ? {ARG_WIDTH{1'b1}}
                                                          : scaled[ARG_WIDTH-1:0];

   assign emit_ext    = CMP_W'(emit_idx_ff);
   assign slot_ext    = CMP_W'(slot_ff);
   assign rd_idx      = emit_ext[SLOT_W-1:0];
   assign emit_is_cur = (emit_ext == slot_ext);
   assign emit_last   = emit_is_cur || (emit_idx_ff == LAST_EMIT);
   assign emit_value  = emit_is_cur ? cur_ff
                      : (arg_valid_ff[rd_idx] ? arg_ff[rd_idx] : '0);
   assign arg0        = (slot_ff == '0) ? cur_ff
                      : (arg_valid_ff[0] ? arg_ff[0] : '0);

   always_comb begin
      res.kind  = acep_pkg::KIND_CONSUMED;
      res.code  = '0;
      res.slot  = '0;
      res.value = '0;
      res.last  = 1'b1;
      in_escape_in = in_escape_ff;
      bracket_in   = bracket_ff;
      slot_in      = slot_ff;
      cur_in       = cur_ff;
      arg_valid_in = arg_valid_ff;
      wr_en        = 1'b0;
      if (b == acep_pkg::ESC_BYTE) begin
         in_escape_in = 1'b1;
         bracket_in   = 1'b0;
         slot_in      = '0;
         cur_in       = '0;
         arg_valid_in = '0;
      end else if (in_escape_ff && !bracket_ff) begin
         if (b == acep_pkg::BRACKET_BYTE) begin
            bracket_in = 1'b1;
         end else begin
            in_escape_in = 1'b0;
            res.kind     = acep_pkg::KIND_UNKNOWN_ESC;
            res.code     = b;
         end
      end else if (in_escape_ff) begin
         if (is_digit) begin
            cur_in = digit_acc;
         end else if (b == acep_pkg::SEMI_BYTE) begin
            if (slot_ff < LAST_SLOT) begin
               wr_en                 = 1'b1;
               arg_valid_in[slot_ff] = 1'b1;
               cur_in                = '0;
               slot_in               = slot_ff + 1'b1;
            end
         end else begin
            in_escape_in = 1'b0;
            bracket_in   = 1'b0;
            res.code     = b;
            if (!is_final) begin
               res.kind = acep_pkg::KIND_ABORTED;
            end else if (b == acep_pkg::AT_BYTE) begin
               res.kind  = acep_pkg::KIND_INSERT_BLANK;
               res.value = (arg0 != '0) ? acep_pkg::VALUE_OUT_W'(arg0)
                                        : acep_pkg::VALUE_OUT_W'(1);
            end else begin
               res.kind  = acep_pkg::KIND_CSI_ARG;
               res.slot  = emit_idx_ff;
               res.value = acep_pkg::VALUE_OUT_W'(emit_value);
               res.last  = emit_last;
            end
         end
      end else begin
         case (b)
            acep_pkg::TAB_BYTE: res.kind = acep_pkg::KIND_TAB;
            acep_pkg::CR_BYTE:  res.kind = acep_pkg::KIND_CR;
            acep_pkg::LF_BYTE:  res.kind = acep_pkg::KIND_NEWLINE;
            acep_pkg::BS_BYTE:  res.kind = acep_pkg::KIND_CONSUMED;
            acep_pkg::BEL_BYTE: res.kind = acep_pkg::KIND_CONSUMED;
            default: begin
               res.kind = acep_pkg::KIND_CHAR;
               res.code = b;
            end
         endcase
      end
   end

   always_comb begin
      if (consume) begin
         emit_idx_in = '0;
      end else if (fire) begin
         emit_idx_in = emit_idx_ff + 1'b1;
      end else begin
         emit_idx_in = emit_idx_ff;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         in_escape_ff <= 1'b0;
         bracket_ff   <= 1'b0;
         slot_ff      <= '0;
         cur_ff       <= '0;
         arg_valid_ff <= '0;
         emit_idx_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         emit_idx_ff <= emit_idx_in;
         if (consume) begin
            in_escape_ff <= in_escape_in;
            bracket_ff   <= bracket_in;
            slot_ff      <= slot_in;
            cur_ff       <= cur_in;
            arg_valid_ff <= arg_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_in;
      end
      if (consume && wr_en) begin
         arg_ff[slot_ff] <= cur_ff;
      end
   end

   a_burst_holds_item: assert property (@(posedge clock) disable iff (reset)
      (emit_idx_ff != '0) |-> in_valid_ff)
      else $error("Argument run in progress without a held item.");

   a_bracket_in_escape: assert property (@(posedge clock) disable iff (reset)
      bracket_ff |-> in_escape_ff)
      else $error("Bracket flag set outside an escape.");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= LAST_SLOT)
      else $error("Argument slot beyond the last slot.");

   a_burst_steps: assert property (@(posedge clock) disable iff (reset)
      (fire && !res.last) |=> (emit_idx_ff == $past(emit_idx_ff) + 1'b1))
      else $error("Argument run index did not advance.");

endmodule

### sv/acep_out_buf.sv
// Two-entry result buffer that decouples the parser from the result channel.
module acep_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  acep_pkg::result_type push_data,
   output logic                 space,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output acep_pkg::result_type rsp_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   acep_pkg::result_type main_ff;
   acep_pkg::result_type skid_ff;
   logic                 main_load, skid_load;

   assign space     = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_load     = 1'b0;
      skid_load     = 1'b0;
      if (!main_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push_valid;
            main_load     = push_valid;
         end
      end else if (push_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_load     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (main_load) begin
         main_ff <= push_data;
      end else if ((!main_valid_ff || rsp_ready) && skid_valid_ff) begin
         main_ff <= skid_ff;
      end
      if (skid_load) begin
         skid_ff <= push_data;
      end
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("Skid entry held while the output entry is empty.");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push_valid)
      else $error("Item pushed into a full result buffer.");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_valid && rsp_ready) |=> (main_valid_ff && !skid_valid_ff))
      else $error("Skid entry not moved forward after a result was taken.");

endmodule

### sv/ansi_csi_escape_parser_top.sv
// Top level of the ANSI CSI escape parser.
//
// The req channel takes one byte of terminal output per item on req_byte_in.
// The rsp channel returns the classification results: kind, code, argument
// slot, argument value and a last flag that marks the final result of a byte.
// Every byte gives exactly one result, except a CSI final byte other than '@',
// which gives one result per collected argument (up to 16), slot 0 first.
// A byte goes into an input register when accepted. Bytes are taken at one per
// cycle while the output buffer has space and no argument run holds that
// register: a final byte with several arguments holds it while the run counter
// steps through the argument store, one result per cycle while there is space.
// A two-entry output buffer keeps req_ready independent of rsp_ready in the
// same cycle; when the receiver stalls, the buffer fills and req_ready drops
// after at most two further results. Synchronous reset clears the escape state
// and the argument valid flags, so no clearing pass over the store is needed.
module ansi_csi_escape_parser_top #(
   parameter int MAX_ARGS  = acep_pkg::MAX_ARGS_DEF,
   parameter int ARG_WIDTH = acep_pkg::ARG_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_kind,
   output logic [7:0]  rsp_code,
   output logic [3:0]  rsp_arg_slot,
   output logic [15:0] rsp_arg_value,
   output logic        rsp_last
);

   logic                 core_valid;
   logic                 core_space;
   acep_pkg::result_type core_data;
   acep_pkg::result_type rsp_data;

   acep_parser #(
      .MAX_ARGS  (MAX_ARGS),
      .ARG_WIDTH (ARG_WIDTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_byte_in (req_byte_in),
      .out_space   (core_space),
      .out_valid   (core_valid),
      .out_data    (core_data)
   );

   acep_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (core_valid),
      .push_data  (core_data),
      .space      (core_space),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_kind      = rsp_data.kind;
   assign rsp_code      = rsp_data.code;
   assign rsp_arg_slot  = rsp_data.slot;
   assign rsp_arg_value = rsp_data.value;
   assign rsp_last      = rsp_data.last;

endmodule

### sim/acep_result_checker.sv
// Result checker for the ANSI CSI escape parser: predicts each byte's results and compares them.
module acep_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_byte_in,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_kind,
   input  logic [7:0]  rsp_code,
   input  logic [3:0]  rsp_arg_slot,
   input  logic [15:0] rsp_arg_value,
   input  logic        rsp_last,
   output int          error_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic                   esc_active;
   logic                   csi_open;
   int                     arg_slot_now;
   logic [15:0]            arg_vals [acep_pkg::MAX_ARGS_DEF];
   acep_pkg::result_type   expected_results [$];
   acep_pkg::result_type   want;

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   task automatic flag_error(input string msg);
      $display("acep_result_checker: %s", msg);
      error_count++;
   endtask

   function automatic void restart_args();
      foreach (arg_vals[i]) arg_vals[i] = '0;
      arg_slot_now = 0;
      csi_open     = 1'b0;
   endfunction

   function automatic acep_pkg::result_type make_result(acep_pkg::kind_type k, logic [7:0] c,
                                                        logic [3:0] s, logic [15:0] v,
                                                        logic l);
      acep_pkg::result_type r;
      r.kind  = k;
      r.code  = c;
      r.slot  = s;
      r.value = v;
      r.last  = l;
      return r;
   endfunction

   function automatic void push_one(acep_pkg::kind_type k, logic [7:0] c, logic [15:0] v);
      expected_results.push_back(make_result(k, c, 4'd0, v, 1'b1));
   endfunction

   function automatic void classify_byte(input logic [7:0] b);
      logic [31:0] acc;
      int          count;
      if (b == acep_pkg::ESC_BYTE) begin
         restart_args();
         esc_active = 1'b1;
         push_one(acep_pkg::KIND_CONSUMED, 8'h00, 16'd0);
      end else if (esc_active && !csi_open) begin
         if (b == acep_pkg::BRACKET_BYTE) begin
            csi_open = 1'b1;
            push_one(acep_pkg::KIND_CONSUMED, 8'h00, 16'd0);
         end else begin
            esc_active = 1'b0;
            push_one(acep_pkg::KIND_UNKNOWN_ESC, b, 16'd0);
         end
      end else if (esc_active) begin
         if (b >= acep_pkg::DIGIT_0 && b <= acep_pkg::DIGIT_9) begin
            acc = 32'(arg_vals[arg_slot_now]) * 32'd10 + 32'(b - acep_pkg::DIGIT_0);
            arg_vals[arg_slot_now] = (acc > 32'hFFFF) ? 16'hFFFF : acc[15:0];
            push_one(acep_pkg::KIND_CONSUMED, 8'h00, 16'd0);
         end else if (b == acep_pkg::SEMI_BYTE) begin
            if (arg_slot_now < acep_pkg::MAX_ARGS_DEF - 1) arg_slot_now++;
            push_one(acep_pkg::KIND_CONSUMED, 8'h00, 16'd0);
         end else begin
            esc_active = 1'b0;
            csi_open   = 1'b0;
            if (b >= acep_pkg::FINAL_LO && b <= acep_pkg::FINAL_HI) begin
               if (b == acep_pkg::AT_BYTE) begin
                  push_one(acep_pkg::KIND_INSERT_BLANK, b,
                           (arg_vals[0] != 16'd0) ? arg_vals[0] : 16'd1);
               end else begin
                  count = arg_slot_now + 1;
                  if (count > acep_pkg::MAX_RESULTS) count = acep_pkg::MAX_RESULTS;
                  for (int i = 0; i < count; i++)
                     expected_results.push_back(make_result(acep_pkg::KIND_CSI_ARG, b, 4'(i),
                        arg_vals[i], (i == count - 1)));
               end
            end else begin
               push_one(acep_pkg::KIND_ABORTED, b, 16'd0);
            end
         end
      end else begin
         case (b)
            acep_pkg::TAB_BYTE: push_one(acep_pkg::KIND_TAB, 8'h00, 16'd0);
            acep_pkg::CR_BYTE:  push_one(acep_pkg::KIND_CR, 8'h00, 16'd0);
            acep_pkg::LF_BYTE:  push_one(acep_pkg::KIND_NEWLINE, 8'h00, 16'd0);
            acep_pkg::BS_BYTE, acep_pkg::BEL_BYTE:
               push_one(acep_pkg::KIND_CONSUMED, 8'h00, 16'd0);
            default:  push_one(acep_pkg::KIND_CHAR, b, 16'd0);
         endcase
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         esc_active = 1'b0;
         restart_args();
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               flag_error($sformatf("result with nothing expected: kind %0d code %02h",
                                    rsp_kind, rsp_code));
            end else begin
               want = expected_results.pop_front();
               if (rsp_kind !== want.kind)
                  flag_error($sformatf("kind %0d, expected %0d", rsp_kind, want.kind));
               if (rsp_code !== want.code)
                  flag_error($sformatf("code %02h, expected %02h", rsp_code, want.code));
               if (rsp_arg_slot !== want.slot)
                  flag_error($sformatf("arg_slot %0d, expected %0d", rsp_arg_slot, want.slot));
               if (rsp_arg_value !== want.value)
                  flag_error($sformatf("arg_value %0d, expected %0d", rsp_arg_value,
                                       want.value));
               if (rsp_last !== want.last)
                  flag_error($sformatf("last %0b, expected %0b", rsp_last, want.last));
            end
         end
         if (req_valid && req_ready) classify_byte(req_byte_in);
      end
      outstanding <= expected_results.size();
   end

endmodule

### sim/tb_ansi_csi_escape_parser_top.sv
// Testbench top for the ANSI CSI escape parser: drives byte streams and gives the verdict.
module tb_ansi_csi_escape_parser_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int BYTE_TARGET    = 280;
   localparam int TAIL_CYCLES    = 40;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_byte_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_kind;
   logic [7:0]  rsp_code;
   logic [3:0]  rsp_arg_slot;
   logic [15:0] rsp_arg_value;
   logic        rsp_last;

   int          mismatch_count;
   int          outstanding_results;
   int          bytes_sent = 0;
   int          idle_cycles = 0;
   bit          no_idle = 1'b0;

   ansi_csi_escape_parser_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_byte_in   (req_byte_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_code      (rsp_code),
      .rsp_arg_slot  (rsp_arg_slot),
      .rsp_arg_value (rsp_arg_value),
      .rsp_last      (rsp_last)
   );

   acep_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_byte_in   (req_byte_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_code      (rsp_code),
      .rsp_arg_slot  (rsp_arg_slot),
      .rsp_arg_value (rsp_arg_value),
      .rsp_last      (rsp_last),
      .error_count   (mismatch_count),
      .outstanding   (outstanding_results)
   );

   always #1 clock = ~clock;

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= value;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_ansi_csi_escape_parser_top: errors");
            $finish;
         end
      end
   end

   initial begin
      int gap;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = idle_length();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin
      logic [7:0] directed [$];
      logic [7:0] pick;
      int         choice;
      int         nargs;
      int         ndig;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_byte_in <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      directed = {8'h41, 8'h00, 8'hFF, acep_pkg::TAB_BYTE, acep_pkg::CR_BYTE,
                  acep_pkg::LF_BYTE, acep_pkg::BS_BYTE, acep_pkg::BEL_BYTE,
                  acep_pkg::ESC_BYTE, 8'h78,
                  acep_pkg::ESC_BYTE, acep_pkg::BRACKET_BYTE, acep_pkg::AT_BYTE,
                  acep_pkg::ESC_BYTE, acep_pkg::BRACKET_BYTE, 8'h37, 8'h30, 8'h30, 8'h30,
                  8'h30, acep_pkg::SEMI_BYTE, 8'h33, 8'h48,
                  acep_pkg::ESC_BYTE, acep_pkg::BRACKET_BYTE, 8'h01};
      foreach (directed[i]) send_byte(directed[i]);

      while (bytes_sent < BYTE_TARGET) begin
         no_idle = ($urandom_range(0, 5) == 0);
         choice  = $urandom_range(0, 99);
         if (choice < 40) begin
            send_byte(acep_pkg::ESC_BYTE);
            send_byte(acep_pkg::BRACKET_BYTE);
            nargs = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
            for (int k = 0; k < nargs; k++) begin
               if (k > 0) send_byte(acep_pkg::SEMI_BYTE);
               ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 3);
               repeat (ndig) send_byte(acep_pkg::DIGIT_0 + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 3) == 0) send_byte(acep_pkg::AT_BYTE);
            else send_byte(8'($urandom_range(acep_pkg::FINAL_LO, acep_pkg::FINAL_HI)));
         end else if (choice < 55) begin
            send_byte(acep_pkg::ESC_BYTE);
            send_byte(acep_pkg::BRACKET_BYTE);
            repeat ($urandom_range(0, 3)) send_byte(acep_pkg::DIGIT_0 + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 1) == 1) send_byte(acep_pkg::SEMI_BYTE);
            case ($urandom_range(0, 3))
               0: pick = 8'($urandom_range(8'h00, 8'h1A));
               1: pick = 8'($urandom_range(8'h1C, 8'h2F));
               2: begin
                  pick = 8'($urandom_range(8'h3A, 8'h3F));
                  if (pick == acep_pkg::SEMI_BYTE) pick = 8'h3F;
               end
               default: pick = 8'($urandom_range(8'h7F, 8'hFF));
            endcase
            send_byte(pick);
         end else if (choice < 65) begin
            send_byte(acep_pkg::ESC_BYTE);
            do pick = 8'($urandom_range(0, 255)); while (pick == acep_pkg::BRACKET_BYTE);
            send_byte(pick);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 3))
                  0, 1: pick = 8'($urandom_range(8'h20, 8'h7E));
                  2: begin
                     case ($urandom_range(0, 4))
                        0: pick = acep_pkg::TAB_BYTE;
                        1: pick = acep_pkg::CR_BYTE;
                        2: pick = acep_pkg::LF_BYTE;
                        3: pick = acep_pkg::BS_BYTE;
                        default: pick = acep_pkg::BEL_BYTE;
                     endcase
                  end
                  default: pick = 8'($urandom_range(0, 255));
               endcase
               send_byte(pick);
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding_results != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_ansi_csi_escape_parser_top: clean");
      end else begin
         $display("tb_ansi_csi_escape_parser_top: errors");
      end
      $finish;
   end

endmodule

### sim.f
sv/acep_pkg.sv
sv/acep_parser.sv
sv/acep_out_buf.sv
sv/ansi_csi_escape_parser_top.sv
sim/acep_result_checker.sv
sim/tb_ansi_csi_escape_parser_top.sv
